// File: design/graph_bfs_dfs_traversal_engine_unit_assert.svh
// Assertion macros for the graph search engine.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ENGINE_UNIT_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define GBT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbt assertion failed");
`define GBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbt assertion failed");
`else
`define GBT_ASSERT_NOW(lbl, ante, cons)
`define GBT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/gbt_pkg.sv
package gbt_pkg;

    localparam int MAX_NODES   = 32;
    localparam int STACK_DEPTH = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int RESULT_CAP  = 32;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int ENT_AW  = 2 * NODE_W;
    localparam int ENT_W   = NODE_W + 2 * WEIGHT_BITS;
    localparam int WORK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int RES_AW  = $clog2(RESULT_CAP);
    localparam int K_W     = $clog2(RESULT_CAP + 1);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 3;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_BFS    = 2'd2;
    localparam logic [1:0] KIND_DFS    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ENT_AW-1:0] waddr;
        logic [ENT_W-1:0]  wdata;
        logic [ENT_AW-1:0] raddr;
    } ent_req_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic [NODE_W-1:0] raddr;
    } cnt_req_t;

    typedef struct packed {
        logic               we;
        logic [WORK_AW-1:0] waddr;
        logic [NODE_W-1:0]  wdata;
        logic [WORK_AW-1:0] raddr;
    } work_req_t;

    typedef struct packed {
        logic              we;
        logic [RES_AW-1:0] waddr;
        logic [NODE_W-1:0] wdata;
        logic [RES_AW-1:0] raddr;
    } res_req_t;

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_CNTA  = 16'b0000_0000_0000_0010,
        S_CNTB  = 16'b0000_0000_0000_0100,
        S_CNTW  = 16'b0000_0000_0000_1000,
        S_ESCAN = 16'b0000_0000_0001_0000,
        S_ECHK  = 16'b0000_0000_0010_0000,
        S_APPA  = 16'b0000_0000_0100_0000,
        S_APPB  = 16'b0000_0000_1000_0000,
        S_POP   = 16'b0000_0001_0000_0000,
        S_VGET  = 16'b0000_0010_0000_0000,
        S_VCNT  = 16'b0000_0100_0000_0000,
        S_NRD   = 16'b0000_1000_0000_0000,
        S_NCHK  = 16'b0001_0000_0000_0000,
        S_RRD   = 16'b0010_0000_0000_0000,
        S_RLD   = 16'b0100_0000_0000_0000,
        S_HOLD  = 16'b1000_0000_0000_0000
    } state_t;

endpackage

// File: design/graph_bfs_dfs_traversal_engine_unit.sv
// Graph search engine: stores an undirected weighted graph and runs edge
// inserts, edge queries, breadth-first and depth-first walks.
// Input stream s_axis_*: one transaction per command; kind in tuser.
// Output stream m_axis_*: one transaction per result; tlast marks the final
// result of a command. Commands are handled one at a time: s_axis_tready is
// high only while no command is in progress and no result is pending.
// Insert and query read both neighbor counts, then scan node_a's neighbor
// entries one at a time; an out-of-range node goes straight to the result.
// A walk pops each node, reads its neighbor count and reads its neighbor
// entries one at a time (a popped node already visited in a depth-first walk
// is skipped), then streams the emitted nodes from the result buffer; the
// single read port of the neighbor-entry memory paces these reads.
// Walk results are buffered until the walk ends, since the overflow flag in
// tuser applies to every result of a depth-first walk.
// Reset clears control state, neighbor counts (valid bits) and sets
// node_count to 32; no clearing pass is needed.
// When the receiver stalls, the current result holds in the output register
// and the engine waits.
// The user writes node_count via cfg_we / cfg_wdata only while the engine is idle; not enforced.
`include "graph_bfs_dfs_traversal_engine_unit_assert.svh"

module graph_bfs_dfs_traversal_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // node_a[4:0], node_b[9:5], travel_time[25:10], fuel_cost[41:26]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // visited_node[4:0], edge_time[20:5], edge_fuel[36:21]
    output logic [2:0]  m_axis_tuser,  // status[1:0], stack_overflowed[2]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);

    gbt_pkg::cnt_req_t  cnt_req;
    gbt_pkg::ent_req_t  ent_req;
    gbt_pkg::work_req_t work_req;
    gbt_pkg::res_req_t  res_req;

    logic [gbt_pkg::CNT_W-1:0]     node_count_reg;
    logic [gbt_pkg::MAX_NODES-1:0] cnt_valid_reg;
    logic                          cnt_rvalid_reg;
    logic [gbt_pkg::CNT_W-1:0]     cnt_ram_rdata, cnt_rdata;
    logic [gbt_pkg::ENT_W-1:0]     ent_rdata;
    logic [gbt_pkg::NODE_W-1:0]    work_rdata, res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= gbt_pkg::CNT_W'(32);
            cnt_valid_reg  <= '0;
            cnt_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cnt_req.we)
            begin
                cnt_valid_reg[cnt_req.waddr] <= 1'b1;
            end
            cnt_rvalid_reg <= cnt_valid_reg[cnt_req.raddr];
        end
    end

    assign cnt_rdata = cnt_rvalid_reg ? cnt_ram_rdata : '0;

    gbt_ram #(.AW(gbt_pkg::NODE_W), .DW(gbt_pkg::CNT_W)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_req.we),
        .waddr (cnt_req.waddr),
        .wdata (cnt_req.wdata),
        .raddr (cnt_req.raddr),
        .rdata (cnt_ram_rdata)
    );

    gbt_ram #(.AW(gbt_pkg::ENT_AW), .DW(gbt_pkg::ENT_W)) u_ent_ram (
        .clk   (clk),
        .we    (ent_req.we),
        .waddr (ent_req.waddr),
        .wdata (ent_req.wdata),
        .raddr (ent_req.raddr),
        .rdata (ent_rdata)
    );

    gbt_ram #(.AW(gbt_pkg::WORK_AW), .DW(gbt_pkg::NODE_W)) u_work_ram (
        .clk   (clk),
        .we    (work_req.we),
        .waddr (work_req.waddr),
        .wdata (work_req.wdata),
        .raddr (work_req.raddr),
        .rdata (work_rdata)
    );

    gbt_ram #(.AW(gbt_pkg::RES_AW), .DW(gbt_pkg::NODE_W)) u_res_ram (
        .clk   (clk),
        .we    (res_req.we),
        .waddr (res_req.waddr),
        .wdata (res_req.wdata),
        .raddr (res_req.raddr),
        .rdata (res_rdata)
    );

    gbt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .node_count (node_count_reg),
        .cnt_req    (cnt_req),
        .cnt_rdata  (cnt_rdata),
        .ent_req    (ent_req),
        .ent_rdata  (ent_rdata),
        .work_req   (work_req),
        .work_rdata (work_rdata),
        .res_req    (res_req),
        .res_rdata  (res_rdata)
    );

    `GBT_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid)
    `GBT_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    `GBT_ASSERT_NEXT(a_cnt_valid_set, cnt_req.we, cnt_valid_reg[$past(cnt_req.waddr)])

endmodule

// File: design/gbt_ram.sv
module gbt_ram #(
    parameter int AW = 5,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/gbt_seq.sv
module gbt_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gbt_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [gbt_pkg::IN_USER_W-1:0]      in_user,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gbt_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [gbt_pkg::OUT_USER_W-1:0]     out_user,
    output logic                               out_last,
    input  logic [gbt_pkg::CNT_W-1:0]          node_count,
    output gbt_pkg::cnt_req_t                  cnt_req,
    input  logic [gbt_pkg::CNT_W-1:0]          cnt_rdata,
    output gbt_pkg::ent_req_t                  ent_req,
    input  logic [gbt_pkg::ENT_W-1:0]          ent_rdata,
    output gbt_pkg::work_req_t                 work_req,
    input  logic [gbt_pkg::NODE_W-1:0]         work_rdata,
    output gbt_pkg::res_req_t                  res_req,
    input  logic [gbt_pkg::NODE_W-1:0]         res_rdata
);

    localparam int NW = gbt_pkg::NODE_W;
    localparam int CW = gbt_pkg::CNT_W;
    localparam int WB = gbt_pkg::WEIGHT_BITS;

    gbt_pkg::state_t state_reg, state_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [NW-1:0]                 a_reg, a_next, b_reg, b_next, v_reg, v_next;
    logic [WB-1:0]                 t_reg, t_next, f_reg, f_next;
    logic [CW-1:0]                 cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CW-1:0]                 cnt_v_reg, cnt_v_next, j_reg, j_next;
    logic [gbt_pkg::WORK_AW:0]     head_reg, head_next, tail_reg, tail_next;
    logic [gbt_pkg::SP_W-1:0]      sp_reg, sp_next;
    logic [gbt_pkg::K_W-1:0]       k_reg, k_next;
    logic [gbt_pkg::RES_AW-1:0]    oi_reg, oi_next;
    logic                          ovf_reg, ovf_next;
    logic [gbt_pkg::MAX_NODES-1:0] marks_reg, marks_next;
    logic [gbt_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [gbt_pkg::OUT_USER_W-1:0] out_user_reg, out_user_next;
    logic                          out_last_reg, out_last_next;

    logic [CW-1:0]  lim;
    logic [1:0]     in_kind;
    logic [NW-1:0]  in_a, in_b, ent_node, w;
    logic [WB-1:0]  ent_time, ent_fuel;
    logic           is_dfs;

    assign lim = (node_count > CW'(gbt_pkg::MAX_NODES)) ? CW'(gbt_pkg::MAX_NODES) : node_count;
    assign in_kind  = in_user[1:0];
    assign in_a     = in_data[NW-1:0];
    assign in_b     = in_data[2*NW-1:NW];
    assign ent_node = ent_rdata[NW-1:0];
    assign ent_time = ent_rdata[NW+WB-1:NW];
    assign ent_fuel = ent_rdata[NW+2*WB-1:NW+WB];
    assign w        = ent_node;
    assign is_dfs   = (kind_reg == gbt_pkg::KIND_DFS);

    assign in_ready  = (state_reg == gbt_pkg::S_IDLE);
    assign out_valid = (state_reg == gbt_pkg::S_HOLD);
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        f_next        = f_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        cnt_v_next    = cnt_v_reg;
        j_next        = j_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        sp_next       = sp_reg;
        k_next        = k_reg;
        oi_next       = oi_reg;
        ovf_next      = ovf_reg;
        marks_next    = marks_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_last_next = out_last_reg;

        cnt_req       = '0;
        cnt_req.raddr = a_reg;
        ent_req       = '0;
        ent_req.raddr = {a_reg, j_reg[NW-1:0]};
        work_req      = '0;
        work_req.raddr = head_reg[gbt_pkg::WORK_AW-1:0];
        res_req       = '0;
        res_req.raddr = oi_reg;

        case (state_reg)
            gbt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_kind;
                    a_next    = in_a;
                    b_next    = in_b;
                    t_next    = in_data[2*NW+WB-1:2*NW];
                    f_next    = in_data[2*NW+2*WB-1:2*NW+WB];
                    out_data_next = '0;
                    out_user_next = {1'b0, gbt_pkg::ST_OK};
                    out_last_next = 1'b1;
                    if (({1'b0, in_a} >= lim) ||
                        (in_kind[1] == 1'b0 && {1'b0, in_b} >= lim))
                    begin
                        out_user_next = {1'b0, gbt_pkg::ST_RANGE};
                        state_next    = gbt_pkg::S_HOLD;
                    end
                    else if (in_kind[1] == 1'b0)
                    begin
                        state_next = gbt_pkg::S_CNTA;
                    end
                    else
                    begin
                        marks_next = '0;
                        if (in_kind == gbt_pkg::KIND_BFS)
                        begin
                            marks_next[in_a] = 1'b1;
                        end
                        work_req.we    = 1'b1;
                        work_req.waddr = '0;
                        work_req.wdata = in_a;
                        head_next  = '0;
                        tail_next  = (gbt_pkg::WORK_AW+1)'(1);
                        sp_next    = gbt_pkg::SP_W'(1);
                        k_next     = '0;
                        ovf_next   = 1'b0;
                        state_next = gbt_pkg::S_POP;
                    end
                end
            end
            gbt_pkg::S_CNTA:
            begin
                cnt_req.raddr = a_reg;
                state_next    = gbt_pkg::S_CNTB;
            end
            gbt_pkg::S_CNTB:
            begin
                cnt_req.raddr = b_reg;
                cnt_a_next    = cnt_rdata;
                state_next    = gbt_pkg::S_CNTW;
            end
            gbt_pkg::S_CNTW:
            begin
                cnt_b_next = cnt_rdata;
                j_next     = '0;
                state_next = gbt_pkg::S_ESCAN;
            end
            gbt_pkg::S_ESCAN:
            begin
                ent_req.raddr = {a_reg, j_reg[NW-1:0]};
                if (j_reg == cnt_a_reg)
                begin
                    if (kind_reg == gbt_pkg::KIND_QUERY)
                    begin
                        out_user_next = {1'b0, gbt_pkg::ST_NOT_FOUND};
                        state_next    = gbt_pkg::S_HOLD;
                    end
                    else
                    begin
                        state_next = gbt_pkg::S_APPA;
                    end
                end
                else
                begin
                    state_next = gbt_pkg::S_ECHK;
                end
            end
            gbt_pkg::S_ECHK:
            begin
                if (ent_node == b_reg)
                begin
                    if (kind_reg == gbt_pkg::KIND_QUERY)
                    begin
                        out_data_next = {3'b000, ent_fuel, ent_time, {NW{1'b0}}};
                    end
                    else
                    begin
                        out_user_next = {1'b0, gbt_pkg::ST_DUPLICATE};
                    end
                    state_next = gbt_pkg::S_HOLD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = gbt_pkg::S_ESCAN;
                end
            end
            gbt_pkg::S_APPA:
            begin
                if (cnt_a_reg < CW'(gbt_pkg::MAX_NODES))
                begin
                    ent_req.we    = 1'b1;
                    ent_req.waddr = {a_reg, cnt_a_reg[NW-1:0]};
                    ent_req.wdata = {f_reg, t_reg, b_reg};
                    cnt_req.we    = 1'b1;
                    cnt_req.waddr = a_reg;
                    cnt_req.wdata = cnt_a_reg + 1'b1;
                end
                state_next = (a_reg != b_reg) ? gbt_pkg::S_APPB : gbt_pkg::S_HOLD;
            end
            gbt_pkg::S_APPB:
            begin
                if (cnt_b_reg < CW'(gbt_pkg::MAX_NODES))
                begin
                    ent_req.we    = 1'b1;
                    ent_req.waddr = {b_reg, cnt_b_reg[NW-1:0]};
                    ent_req.wdata = {f_reg, t_reg, a_reg};
                    cnt_req.we    = 1'b1;
                    cnt_req.waddr = b_reg;
                    cnt_req.wdata = cnt_b_reg + 1'b1;
                end
                state_next = gbt_pkg::S_HOLD;
            end
            gbt_pkg::S_POP:
            begin
                if (is_dfs)
                begin
                    work_req.raddr = gbt_pkg::WORK_AW'(sp_reg - 1'b1);
                    if (sp_reg == '0)
                    begin
                        oi_next    = '0;
                        state_next = gbt_pkg::S_RRD;
                    end
                    else
                    begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = gbt_pkg::S_VGET;
                    end
                end
                else
                begin
                    work_req.raddr = head_reg[gbt_pkg::WORK_AW-1:0];
                    if (head_reg == tail_reg)
                    begin
                        oi_next    = '0;
                        state_next = gbt_pkg::S_RRD;
                    end
                    else
                    begin
                        head_next  = head_reg + 1'b1;
                        state_next = gbt_pkg::S_VGET;
                    end
                end
            end
            gbt_pkg::S_VGET:
            begin
                cnt_req.raddr = work_rdata;
                v_next        = work_rdata;
                if (is_dfs && marks_reg[work_rdata])
                begin
                    state_next = gbt_pkg::S_POP;
                end
                else
                begin
                    if (k_reg < gbt_pkg::K_W'(gbt_pkg::RESULT_CAP))
                    begin
                        res_req.we    = 1'b1;
                        res_req.waddr = k_reg[gbt_pkg::RES_AW-1:0];
                        res_req.wdata = work_rdata;
                        k_next        = k_reg + 1'b1;
                    end
                    if (is_dfs)
                    begin
                        marks_next[work_rdata] = 1'b1;
                    end
                    state_next = gbt_pkg::S_VCNT;
                end
            end
            gbt_pkg::S_VCNT:
            begin
                cnt_v_next = cnt_rdata;
                j_next     = '0;
                state_next = gbt_pkg::S_NRD;
            end
            gbt_pkg::S_NRD:
            begin
                ent_req.raddr = {v_reg, j_reg[NW-1:0]};
                state_next    = (j_reg == cnt_v_reg) ? gbt_pkg::S_POP : gbt_pkg::S_NCHK;
            end
            gbt_pkg::S_NCHK:
            begin
                if (({1'b0, w} < lim) && !marks_reg[w])
                begin
                    if (is_dfs)
                    begin
                        if (sp_reg < gbt_pkg::SP_W'(gbt_pkg::STACK_DEPTH))
                        begin
                            work_req.we    = 1'b1;
                            work_req.waddr = sp_reg[gbt_pkg::WORK_AW-1:0];
                            work_req.wdata = w;
                            sp_next        = sp_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (tail_reg < (gbt_pkg::WORK_AW+1)'(gbt_pkg::MAX_NODES))
                    begin
                        marks_next[w]  = 1'b1;
                        work_req.we    = 1'b1;
                        work_req.waddr = tail_reg[gbt_pkg::WORK_AW-1:0];
                        work_req.wdata = w;
                        tail_next      = tail_reg + 1'b1;
                    end
                end
                j_next     = j_reg + 1'b1;
                state_next = gbt_pkg::S_NRD;
            end
            gbt_pkg::S_RRD:
            begin
                res_req.raddr = oi_reg;
                state_next    = gbt_pkg::S_RLD;
            end
            gbt_pkg::S_RLD:
            begin
                out_data_next = {{(gbt_pkg::OUT_DATA_W-NW){1'b0}}, res_rdata};
                out_user_next = {ovf_reg & is_dfs, gbt_pkg::ST_OK};
                out_last_next = ({1'b0, oi_reg} == (k_reg - 1'b1));
                state_next    = gbt_pkg::S_HOLD;
            end
            gbt_pkg::S_HOLD:
            begin
                if (out_ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = gbt_pkg::S_IDLE;
                    end
                    else
                    begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = gbt_pkg::S_RRD;
                    end
                end
            end
            default:
            begin
                state_next = gbt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbt_pkg::S_IDLE;
            marks_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            sp_reg    <= '0;
            k_reg     <= '0;
            oi_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            marks_reg <= marks_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            sp_reg    <= sp_next;
            k_reg     <= k_next;
            oi_reg    <= oi_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        v_reg        <= v_next;
        t_reg        <= t_next;
        f_reg        <= f_next;
        cnt_a_reg    <= cnt_a_next;
        cnt_b_reg    <= cnt_b_next;
        cnt_v_reg    <= cnt_v_next;
        j_reg        <= j_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: sim/tb_graph_bfs_dfs_traversal_engine_unit.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  visited_node;
    logic [15:0] edge_time;
    logic [15:0] edge_fuel;
    logic        last;
    logic        stack_overflowed;
} graph_result_t;

class graph_scoreboard;
    int unsigned   node_limit;
    int unsigned   nbr_count [32];
    logic [4:0]    nbr_node [32][32];
    logic [15:0]   nbr_time [32][32];
    logic [15:0]   nbr_fuel [32][32];
    graph_result_t pending_results [$];
    int            error_count;

    function new();
        node_limit = 32;
        error_count = 0;
        foreach (nbr_count[i]) nbr_count[i] = 0;
    endfunction

    function void set_node_count(logic [5:0] v);
        node_limit = (v > 32) ? 32 : v;
    endfunction

    function void push_result(logic [1:0] st, logic [4:0] nd, logic [15:0] t,
                              logic [15:0] f, logic lst, logic ovf);
        graph_result_t r;
        r.status = st;
        r.visited_node = nd;
        r.edge_time = t;
        r.edge_fuel = f;
        r.last = lst;
        r.stack_overflowed = ovf;
        pending_results.push_back(r);
    endfunction

    function int find_neighbor(int a, int b);
        for (int j = 0; j < nbr_count[a]; j++)
            if (nbr_node[a][j] == b) return j;
        return -1;
    endfunction

    function void add_neighbor(int a, int b, logic [15:0] t, logic [15:0] f);
        if (nbr_count[a] < 32)
        begin
            nbr_node[a][nbr_count[a]] = 5'(b);
            nbr_time[a][nbr_count[a]] = t;
            nbr_fuel[a][nbr_count[a]] = f;
            nbr_count[a]++;
        end
    endfunction

    function void note_command(logic [1:0] kind, logic [4:0] a, logic [4:0] b,
                               logic [15:0] t, logic [15:0] f);
        int          e;
        logic [31:0] marks;
        int          walk [$];
        int          work [$];
        int          v, w;
        logic        ovf;
        marks = 0;
        ovf = 0;
        if (kind == gbt_pkg::KIND_INSERT || kind == gbt_pkg::KIND_QUERY)
        begin
            if (a >= node_limit || b >= node_limit)
            begin
                push_result(gbt_pkg::ST_RANGE, 0, 0, 0, 1, 0);
                return;
            end
            e = find_neighbor(a, b);
            if (kind == gbt_pkg::KIND_INSERT)
            begin
                if (e >= 0)
                    push_result(gbt_pkg::ST_DUPLICATE, 0, 0, 0, 1, 0);
                else
                begin
                    add_neighbor(a, b, t, f);
                    if (a != b) add_neighbor(b, a, t, f);
                    push_result(gbt_pkg::ST_OK, 0, 0, 0, 1, 0);
                end
            end
            else if (e < 0)
                push_result(gbt_pkg::ST_NOT_FOUND, 0, 0, 0, 1, 0);
            else
                push_result(gbt_pkg::ST_OK, 0, nbr_time[a][e], nbr_fuel[a][e], 1, 0);
            return;
        end
        if (a >= node_limit)
        begin
            push_result(gbt_pkg::ST_RANGE, 0, 0, 0, 1, 0);
            return;
        end
        if (kind == gbt_pkg::KIND_BFS)
        begin
            marks[a] = 1;
            work.push_back(a);
            for (int h = 0; h < work.size(); h++)
            begin
                v = work[h];
                walk.push_back(v);
                for (int j = 0; j < nbr_count[v]; j++)
                begin
                    w = nbr_node[v][j];
                    if (w < node_limit && !marks[w] && work.size() < 32)
                    begin
                        marks[w] = 1;
                        work.push_back(w);
                    end
                end
            end
        end
        else
        begin
            work.push_back(a);
            while (work.size() > 0)
            begin
                v = work.pop_back();
                if (marks[v]) continue;
                walk.push_back(v);
                marks[v] = 1;
                for (int j = 0; j < nbr_count[v]; j++)
                begin
                    w = nbr_node[v][j];
                    if (w < node_limit && !marks[w])
                    begin
                        if (work.size() < gbt_pkg::STACK_DEPTH) work.push_back(w);
                        else ovf = 1;
                    end
                end
            end
        end
        if (walk.size() > gbt_pkg::RESULT_CAP) walk = walk[0:gbt_pkg::RESULT_CAP-1];
        foreach (walk[i])
            push_result(gbt_pkg::ST_OK, 5'(walk[i]), 0, 0, i == walk.size() - 1,
                        (kind == gbt_pkg::KIND_DFS) ? ovf : 1'b0);
    endfunction

    function void check_result(graph_result_t act);
        graph_result_t exp_r;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result %p", $realtime, act);
            error_count++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (act !== exp_r)
        begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, act);
            error_count++;
        end
    endfunction
endclass

module tb_graph_bfs_dfs_traversal_engine_unit;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we = 0;
    logic [5:0]  cfg_wdata = 0;
    logic        sink_active = 0;

    graph_scoreboard sb;

    graph_bfs_dfs_traversal_engine_unit dut (.*);

    always #4 clk = ~clk;

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
               ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    endfunction

    task automatic send_command(logic [1:0] kind, logic [4:0] a, logic [4:0] b,
                                logic [15:0] t, logic [15:0] f, bit no_gap);
        int gap;
        gap = no_gap ? 1 : 1 + short_gap();
        repeat (gap) @(negedge clk);
        s_axis_tdata <= {6'd0, f, t, b, a};
        s_axis_tuser <= kind;
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_command(kind, a, b, t, f);
        @(negedge clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (sb.pending_results.size() > 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (300) @(negedge clk);
    endtask

    task automatic write_node_count(logic [5:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_node_count(v);
    endtask

    task automatic random_command(int lim);
        logic [1:0] kind;
        int         hi;
        hi = (lim > 0) ? lim - 1 : 0;
        kind = $urandom_range(0, 9) < 5 ? gbt_pkg::KIND_INSERT : 2'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0)
            send_command(kind, 5'($urandom), 5'($urandom), 16'($urandom),
                         16'($urandom), 0);
        else
            send_command(kind, 5'($urandom_range(0, hi)), 5'($urandom_range(0, hi)),
                         16'($urandom), 16'($urandom), 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser[1:0], m_axis_tdata[4:0], m_axis_tdata[20:5],
                             m_axis_tdata[36:21], m_axis_tlast, m_axis_tuser[2]});
    end

    always @(negedge clk)
    begin
        if (sink_active)
            m_axis_tready <= ($urandom_range(0, 29) == 0) ? 1'b0 :
                             ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= 1;
    end

    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (7) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_command(gbt_pkg::KIND_BFS, 0, 0, 0, 0, 0);
        send_command(gbt_pkg::KIND_QUERY, 0, 1, 0, 0, 0);
        send_command(gbt_pkg::KIND_INSERT, 0, 1, 16'hFFFF, 16'h0000, 0);
        send_command(gbt_pkg::KIND_INSERT, 1, 0, 1, 1, 0);
        send_command(gbt_pkg::KIND_INSERT, 31, 31, 16'h0000, 16'hFFFF, 0);
        send_command(gbt_pkg::KIND_INSERT, 31, 31, 5, 5, 0);
        send_command(gbt_pkg::KIND_INSERT, 1, 31, 16'hA5A5, 16'h5A5A, 0);
        send_command(gbt_pkg::KIND_QUERY, 1, 0, 0, 0, 0);
        send_command(gbt_pkg::KIND_QUERY, 31, 1, 0, 0, 0);
        send_command(gbt_pkg::KIND_QUERY, 2, 3, 0, 0, 0);
        send_command(gbt_pkg::KIND_BFS, 0, 0, 0, 0, 0);
        send_command(gbt_pkg::KIND_DFS, 31, 0, 0, 0, 0);
        write_node_count(6'd63);
        send_command(gbt_pkg::KIND_DFS, 0, 0, 0, 0, 0);
        write_node_count(6'd2);
        send_command(gbt_pkg::KIND_BFS, 0, 0, 0, 0, 0);
        send_command(gbt_pkg::KIND_INSERT, 2, 0, 1, 1, 0);
        send_command(gbt_pkg::KIND_DFS, 31, 0, 0, 0, 0);
        write_node_count(6'd0);
        send_command(gbt_pkg::KIND_QUERY, 0, 0, 0, 0, 0);
        send_command(gbt_pkg::KIND_BFS, 0, 0, 0, 0, 0);
        write_node_count(6'd32);
        sink_active = 1;
        for (int i = 0; i < 60; i++) random_command(32);
        drain();
        // dense clique on low nodes to push the depth-first stack over its depth
        write_node_count(6'd14);
        for (int i = 0; i < 14; i++)
            for (int j = i + 1; j < 14; j++)
                send_command(gbt_pkg::KIND_INSERT, 5'(i), 5'(j), 16'($urandom),
                             16'($urandom), $urandom_range(0, 1) != 0);
        send_command(gbt_pkg::KIND_DFS, 0, 0, 0, 0, 0);
        send_command(gbt_pkg::KIND_BFS, 13, 0, 0, 0, 0);
        for (int i = 0; i < 40; i++) random_command(14);
        write_node_count(6'd1);
        for (int i = 0; i < 10; i++) random_command(2);
        write_node_count(6'd32);
        for (int i = 0; i < 130; i++) random_command(32);
        drain();
        for (int i = 0; i < 10; i++) random_command(32);
        drain();
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
